/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the phase rotator.
// No dependencies; SYNTH compiles every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, clocked by clk, off while rst_n is low
`define BPR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bessel_phase_rotator: assertion failed");

// next-cycle implication, clocked by clk, off while rst_n is low
`define BPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bessel_phase_rotator: assertion failed");

`else

`define BPR_ASSERT(lbl, ante, cons)
`define BPR_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* sv/bpr_pkg.sv */
// Shared widths, CORDIC constants, term codes and sideband type for the phase rotator.
// No dependencies.
package bpr_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int VALUE_BITS   = 18;
  localparam int ORDER_W      = 8;
  localparam int FUNC_W       = 2;
  localparam int OUT_W        = 20;

  // CORDIC: Q28 data, angles in 32-bit turns
  localparam int CORDIC_STEPS = 20;
  localparam int CRD_STAGES   = CORDIC_STEPS + 2;  // fold, steps, unfold
  localparam int TRIG_W       = 32;
  localparam int TURN_W       = 32;
  localparam logic signed [TRIG_W-1:0] X_INIT = TRIG_W'(163008219);

  localparam logic signed [TURN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    TURN_W'(536870912), TURN_W'(316933406), TURN_W'(167458908), TURN_W'(85004757),
    TURN_W'(42667332),  TURN_W'(21354465),  TURN_W'(10679838),  TURN_W'(5340245),
    TURN_W'(2670163),   TURN_W'(1335087),   TURN_W'(667544),    TURN_W'(333772),
    TURN_W'(166886),    TURN_W'(83443),     TURN_W'(41722),     TURN_W'(20861),
    TURN_W'(10430),     TURN_W'(5215),      TURN_W'(2608),      TURN_W'(1304)
  };

  // arithmetic widths
  localparam int SUMDIF_W   = VALUE_BITS + 1;
  localparam int TERM_W     = VALUE_BITS + 2;
  localparam int PROD_W     = SUMDIF_W + TRIG_W;
  localparam int ROT_W      = TERM_W + TRIG_W;
  localparam int TERM_SHIFT = 29;  // Q16 * Q28 -> Q16, folds in the 0.5
  localparam int ROT_SHIFT  = 28;  // Q16 * Q28 -> Q16

  typedef enum logic [FUNC_W-1:0] {
    FN_ZERO   = 2'd0,
    FN_FIRST  = 2'd1,
    FN_SECOND = 2'd2
  } func_t;

  typedef struct packed {
    logic [FUNC_W-1:0]            func;
    logic signed [VALUE_BITS-1:0] here;
    logic signed [SUMDIF_W-1:0]   sum;
    logic signed [SUMDIF_W-1:0]   dif;
  } side_t;

endpackage

/* sv/bpr_cordic.sv */
// Pipelined rotation-mode CORDIC: Q28 cosine and sine of an angle in turns.
// Depends on bpr_pkg; one register stage per enable bit.
module bpr_cordic (
  input  logic                                clk,
  input  logic [bpr_pkg::CRD_STAGES-1:0]      en,
  input  logic [bpr_pkg::ANGLE_BITS-1:0]      angle,
  output logic signed [bpr_pkg::TRIG_W-1:0]   cos_out,
  output logic signed [bpr_pkg::TRIG_W-1:0]   sin_out
);
  import bpr_pkg::*;

  logic [TURN_W-1:0]        a_wide;
  logic                     flip_nxt;
  logic signed [TURN_W-1:0] z_nxt;

  logic signed [TRIG_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] y_r [CORDIC_STEPS+1];
  logic signed [TURN_W-1:0] z_r [CORDIC_STEPS];
  logic                     flip_r [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] cos_r;
  logic signed [TRIG_W-1:0] sin_r;

  // 2nd/3rd quadrant: turn by half a turn, negate at the end
  always_comb begin
    a_wide   = TURN_W'(angle) << (TURN_W - ANGLE_BITS);
    flip_nxt = a_wide[TURN_W-1] ^ a_wide[TURN_W-2];
    z_nxt    = {a_wide[TURN_W-1] ^ flip_nxt, a_wide[TURN_W-2:0]};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]    <= X_INIT;
      y_r[0]    <= '0;
      z_r[0]    <= z_nxt;
      flip_r[0] <= flip_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][TURN_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        end
      end
    end
    if (i < CORDIC_STEPS - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en[i+1]) begin
          if (!z_r[i][TURN_W-1]) begin
            z_r[i+1] <= z_r[i] - ATAN_TURNS[i];
          end else begin
            z_r[i+1] <= z_r[i] + ATAN_TURNS[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[CRD_STAGES-1]) begin
      cos_r <= flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
      sin_r <= flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    end
  end

  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule

/* sv/bessel_phase_rotator.sv */
// Bessel phase rotator: e^{i*n*p} times a Bessel term, Q3.16 saturated out.
// Depth: 27 stages, from the stage 0 input capture to the stage 26 output register.
// One transaction per cycle unless stalled; a stage stalls only when it and all later ones are full.
// Reset: synchronous active-low rst_n clears the stage valid bits; data registers are not reset.
// Depends on bpr_pkg, bpr_cordic and assert_macros.svh.
`include "assert_macros.svh"
module bessel_phase_rotator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bpr_pkg::FUNC_W-1:0]           in_func,
  input  logic signed [bpr_pkg::VALUE_BITS-1:0] in_bessel_here,
  input  logic signed [bpr_pkg::VALUE_BITS-1:0] in_bessel_below,
  input  logic signed [bpr_pkg::VALUE_BITS-1:0] in_bessel_above,
  input  logic signed [bpr_pkg::ORDER_W-1:0]   in_order,
  input  logic [bpr_pkg::ANGLE_BITS-1:0]       in_angle,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bpr_pkg::OUT_W-1:0]     out_real_part,
  output logic signed [bpr_pkg::OUT_W-1:0]     out_imag_part
);
  import bpr_pkg::*;

  // stage map
  //   0        : input capture, n*p mod one turn, Jm+Jp and Jm-Jp
  //   1..22    : two CORDICs side by side (fold, 20 steps, unfold)
  //   23       : term products sum*trig, dif*trig
  //   24       : round to Q16, build (tr, ti) per func
  //   25       : rotation products
  //   26       : combine, round, saturate (output register)
  localparam int STG_TERMP = CRD_STAGES + 1;
  localparam int STG_TERM  = STG_TERMP + 1;
  localparam int STG_ROTP  = STG_TERM + 1;
  localparam int STG_OUT   = STG_ROTP + 1;
  localparam int NST       = STG_OUT + 1;

  localparam int SUM_W = ROT_W + 1;
  localparam int SH_W  = SUM_W - ROT_SHIFT;

  localparam logic signed [PROD_W-1:0] TERM_RND = PROD_W'(1) << (TERM_SHIFT - 1);
  localparam logic signed [SUM_W-1:0]  ROT_RND  = SUM_W'(1) << (ROT_SHIFT - 1);

  // ---------------------------------------------------------------
  // flow control: valid bits ride with the data; a stage loads when
  // it is empty or its content moves on. Bubbles get squeezed out.
  // ---------------------------------------------------------------
  logic [NST-1:0] valid_r;
  logic [NST-1:0] valid_nxt;
  logic [NST-1:0] en;

  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !((&valid_r[NST-1:k]) && out_stall);
  end

  assign valid_nxt = {valid_r[NST-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_nxt[k];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = valid_r[STG_OUT];

  // ---------------------------------------------------------------
  // stage 0: capture, phase product wraps modulo one turn
  // ---------------------------------------------------------------
  logic [ANGLE_BITS-1:0] order_ext;
  logic [ANGLE_BITS-1:0] angle_r;
  logic [ANGLE_BITS-1:0] np_r;
  side_t                 side_nxt;
  side_t                 side_r [STG_TERMP];

  always_comb begin
    order_ext     = ANGLE_BITS'(in_order);
    side_nxt.func = in_func;
    side_nxt.here = in_bessel_here;
    side_nxt.sum  = SUMDIF_W'(in_bessel_below) + SUMDIF_W'(in_bessel_above);
    side_nxt.dif  = SUMDIF_W'(in_bessel_below) - SUMDIF_W'(in_bessel_above);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      angle_r   <= in_angle;
      np_r      <= ANGLE_BITS'(in_angle * order_ext);
      side_r[0] <= side_nxt;
    end
  end

  // sideband follows the CORDIC stages
  for (genvar k = 1; k < STG_TERMP; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // stages 1..22: cos/sin of n*p and of p
  // ---------------------------------------------------------------
  logic signed [TRIG_W-1:0] cos_np;
  logic signed [TRIG_W-1:0] sin_np;
  logic signed [TRIG_W-1:0] cos_p;
  logic signed [TRIG_W-1:0] sin_p;

  bpr_cordic u_crd_np (
    .clk     (clk),
    .en      (en[STG_TERMP-1:1]),
    .angle   (np_r),
    .cos_out (cos_np),
    .sin_out (sin_np)
  );

  bpr_cordic u_crd_p (
    .clk     (clk),
    .en      (en[STG_TERMP-1:1]),
    .angle   (angle_r),
    .cos_out (cos_p),
    .sin_out (sin_p)
  );

  // ---------------------------------------------------------------
  // stage 23: term products; first kind pairs sum/cos, dif/sin,
  // second kind sum/sin, dif/cos
  // ---------------------------------------------------------------
  side_t                    last_side;
  logic                     use_first;
  logic signed [TRIG_W-1:0] trig_a;
  logic signed [TRIG_W-1:0] trig_b;

  logic [FUNC_W-1:0]            term_func_r;
  logic signed [VALUE_BITS-1:0] term_here_r;
  logic signed [PROD_W-1:0]     prod_a_r;
  logic signed [PROD_W-1:0]     prod_b_r;
  logic signed [TRIG_W-1:0]     term_cos_r;
  logic signed [TRIG_W-1:0]     term_sin_r;

  always_comb begin
    last_side = side_r[STG_TERMP-1];
    use_first = (func_t'(last_side.func) == FN_FIRST);
    trig_a    = use_first ? cos_p : sin_p;
    trig_b    = use_first ? sin_p : cos_p;
  end

  always_ff @(posedge clk) begin
    if (en[STG_TERMP]) begin
      term_func_r <= last_side.func;
      term_here_r <= last_side.here;
      prod_a_r    <= last_side.sum * trig_a;
      prod_b_r    <= last_side.dif * trig_b;
      term_cos_r  <= cos_np;
      term_sin_r  <= sin_np;
    end
  end

  // ---------------------------------------------------------------
  // stage 24: round half up to Q16 (the >>29 carries the 0.5)
  // ---------------------------------------------------------------
  logic signed [PROD_W-1:0] rnd_a;
  logic signed [PROD_W-1:0] rnd_b;
  logic signed [TERM_W-1:0] half_a;
  logic signed [TERM_W-1:0] half_b;
  logic signed [TERM_W-1:0] tr_nxt;
  logic signed [TERM_W-1:0] ti_nxt;

  logic signed [TERM_W-1:0] tr_r;
  logic signed [TERM_W-1:0] ti_r;
  logic signed [TRIG_W-1:0] rot_cos_r;
  logic signed [TRIG_W-1:0] rot_sin_r;

  always_comb begin
    rnd_a  = prod_a_r + TERM_RND;
    rnd_b  = prod_b_r + TERM_RND;
    half_a = rnd_a[TERM_SHIFT+TERM_W-1:TERM_SHIFT];
    half_b = rnd_b[TERM_SHIFT+TERM_W-1:TERM_SHIFT];
    case (func_t'(term_func_r))
      FN_ZERO: begin
        tr_nxt = TERM_W'(term_here_r);
        ti_nxt = '0;
      end
      FN_FIRST: begin
        tr_nxt = half_a;
        ti_nxt = -half_b;
      end
      FN_SECOND: begin
        tr_nxt = half_a;
        ti_nxt = half_b;
      end
      default: begin  // unused selector: zero term, zero result
        tr_nxt = '0;
        ti_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[STG_TERM]) begin
      tr_r      <= tr_nxt;
      ti_r      <= ti_nxt;
      rot_cos_r <= term_cos_r;
      rot_sin_r <= term_sin_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 25: complex multiply by e^{i*n*p}, four products
  // ---------------------------------------------------------------
  logic signed [ROT_W-1:0] p_rc_r;
  logic signed [ROT_W-1:0] p_is_r;
  logic signed [ROT_W-1:0] p_rs_r;
  logic signed [ROT_W-1:0] p_ic_r;

  always_ff @(posedge clk) begin
    if (en[STG_ROTP]) begin
      p_rc_r <= tr_r * rot_cos_r;
      p_is_r <= ti_r * rot_sin_r;
      p_rs_r <= tr_r * rot_sin_r;
      p_ic_r <= ti_r * rot_cos_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 26: Q44 sums, round half up to Q16, saturate to Q3.16
  // ---------------------------------------------------------------
  function automatic logic signed [OUT_W-1:0] sat_q(input logic [SH_W-1:0] v);
    logic [SH_W-OUT_W:0] hi;
    logic                fits;
    hi   = v[SH_W-1:OUT_W-1];
    fits = (&hi) | ~(|hi);
    if (fits) begin
      sat_q = v[OUT_W-1:0];
    end else if (v[SH_W-1]) begin
      sat_q = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_q = {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  logic signed [SUM_W-1:0] re_sum;
  logic signed [SUM_W-1:0] im_sum;
  logic signed [OUT_W-1:0] out_real_r;
  logic signed [OUT_W-1:0] out_imag_r;

  always_comb begin
    re_sum = SUM_W'(p_rc_r) - SUM_W'(p_is_r) + ROT_RND;
    im_sum = SUM_W'(p_rs_r) + SUM_W'(p_ic_r) + ROT_RND;
  end

  always_ff @(posedge clk) begin
    if (en[STG_OUT]) begin
      out_real_r <= sat_q(re_sum[SUM_W-1:ROT_SHIFT]);
      out_imag_r <= sat_q(im_sum[SUM_W-1:ROT_SHIFT]);
    end
  end

  assign out_real_part = out_real_r;
  assign out_imag_part = out_imag_r;

  // ---------------------------------------------------------------
  // checks: occupancy tracks the two handshakes, stall only when full
  // ---------------------------------------------------------------
  `BPR_ASSERT(a_stall_only_full, in_stall, &valid_r)
  `BPR_ASSERT_NXT(a_fill, (in_valid && !in_stall) && !(out_valid && !out_stall), $countones(valid_r) == $past($countones(valid_r)) + 1)
  `BPR_ASSERT_NXT(a_drain, !(in_valid && !in_stall) && (out_valid && !out_stall), $countones(valid_r) + 1 == $past($countones(valid_r)))
  `BPR_ASSERT_NXT(a_steady, (in_valid && !in_stall) && (out_valid && !out_stall), $countones(valid_r) == $past($countones(valid_r)))

endmodule

/* bench/bessel_phase_rotator_test.sv */
// Self-checking bench for bessel_phase_rotator: directed and random transactions,
// predicted in Q28/Q16 fixed point and compared in order. Depends on bpr_pkg.
`timescale 1ns / 1ps

module bessel_phase_rotator_test;
  import bpr_pkg::*;

  // ---------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------
  localparam int   FN_UNUSED_CODE    = 3;      // selector three: result forced to zero
  localparam int   STEP_COUNT        = 20;     // CORDIC iterations
  localparam longint CORDIC_X_START  = 163008219;  // 1/K in Q28
  localparam longint TERM_ROUND      = 64'sd268435456;  // 2^28, half of the >>29
  localparam longint ROT_ROUND       = 64'sd134217728;  // 2^27, half of the >>28
  localparam longint OUT_HI          = 524287;
  localparam longint OUT_LO          = -524288;
  localparam int   J_MAX             = 131071;
  localparam int   J_MIN             = -131072;

  localparam int   IDLE_PCT          = 17;     // per-cycle idle / stall odds
  localparam int   HOLD_CYCLES       = 240;    // long receiver hold, well past pipe depth
  localparam int   DRAIN_CYCLES      = 40;     // pipe is 27 stages deep
  localparam int   WATCHDOG_LIMIT    = 2000;   // cycles with no transaction at all

  localparam longint ARCTAN_TURNS [STEP_COUNT] = '{
    536870912, 316933406, 167458908, 85004757, 42667332,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304
  };

  typedef struct {
    logic [FUNC_W-1:0]            func;
    logic signed [VALUE_BITS-1:0] here;
    logic signed [VALUE_BITS-1:0] below;
    logic signed [VALUE_BITS-1:0] above;
    logic signed [ORDER_W-1:0]    order;
    logic [ANGLE_BITS-1:0]        angle;
  } rotor_req_t;

  typedef struct {
    logic signed [OUT_W-1:0] real_part;
    logic signed [OUT_W-1:0] imag_part;
  } rotor_result_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts each accepted transaction and checks results in order
  // ---------------------------------------------------------------------------
  class rotation_scoreboard;
    rotor_result_t pending_rotations[$];
    int unsigned   mismatches;

    function new();
      mismatches = 0;
    endfunction

    // cos/sin in Q28 of an angle in 32-bit turns
    function void cordic_turns(input logic [31:0] turn, output longint c, output longint s);
      logic [31:0] a;
      longint      x, y, z, xn;
      bit          flip;
      a    = turn;
      flip = 1'b0;
      x    = CORDIC_X_START;
      y    = 0;
      xn   = 0;
      // quadrants two and three: rotate by half a turn, negate at the end
      if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
        a    = a + 32'h8000_0000;
        flip = 1'b1;
      end
      z = $signed(a);
      for (int i = 0; i < STEP_COUNT; i++) begin
        if (z >= 0) begin
          xn = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - ARCTAN_TURNS[i];
        end else begin
          xn = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + ARCTAN_TURNS[i];
        end
        x = xn;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function logic signed [OUT_W-1:0] clamp_q3(input longint v);
      if (v > OUT_HI) v = OUT_HI;
      if (v < OUT_LO) v = OUT_LO;
      return v[OUT_W-1:0];
    endfunction

    function rotor_result_t rotate_term(input rotor_req_t r);
      rotor_result_t         res;
      longint                jh, jb, ja, n, p, np_full;
      longint                cp, sp, cn, sn, tr, ti, sum, dif;
      logic [ANGLE_BITS-1:0] np_bits;
      res.real_part = '0;
      res.imag_part = '0;
      if (r.func == FUNC_W'(FN_UNUSED_CODE)) return res;
      jh = r.here;
      jb = r.below;
      ja = r.above;
      n  = r.order;
      p  = r.angle;
      // n*p wraps modulo one turn
      np_full = n * p;
      np_bits = np_full[ANGLE_BITS-1:0];
      cordic_turns(32'(np_bits) << (32 - ANGLE_BITS), cn, sn);
      if (r.func == FN_ZERO) begin
        tr = jh;
        ti = 0;
      end else begin
        cordic_turns(32'(r.angle) << (32 - ANGLE_BITS), cp, sp);
        sum = jb + ja;
        dif = jb - ja;
        // >>29 folds in the 0.5 and rounds half up to Q16
        if (r.func == FN_FIRST) begin
          tr = (sum * cp + TERM_ROUND) >>> 29;
          ti = -((dif * sp + TERM_ROUND) >>> 29);
        end else begin
          tr = (sum * sp + TERM_ROUND) >>> 29;
          ti = (dif * cp + TERM_ROUND) >>> 29;
        end
      end
      res.real_part = clamp_q3((tr * cn - ti * sn + ROT_ROUND) >>> 28);
      res.imag_part = clamp_q3((tr * sn + ti * cn + ROT_ROUND) >>> 28);
      return res;
    endfunction

    function void note_input(input rotor_req_t req);
      pending_rotations.push_back(rotate_term(req));
    endfunction

    function void check_result(input logic signed [OUT_W-1:0] re,
                               input logic signed [OUT_W-1:0] im);
      rotor_result_t want;
      if (pending_rotations.size() == 0) begin
        mismatches++;
        $display("%0t: result with none pending, expected nothing, actual %0d %0d",
                 $time, re, im);
        return;
      end
      want = pending_rotations.pop_front();
      if (re !== want.real_part) begin
        mismatches++;
        $display("%0t: real_part mismatch, expected %0d, actual %0d",
                 $time, want.real_part, re);
      end
      if (im !== want.imag_part) begin
        mismatches++;
        $display("%0t: imag_part mismatch, expected %0d, actual %0d",
                 $time, want.imag_part, im);
      end
    endfunction

    function int pending_count();
      return pending_rotations.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                         clk             = 1'b0;
  logic                         rst_n           = 1'b0;
  logic                         in_valid        = 1'b0;
  logic                         in_stall;
  logic [FUNC_W-1:0]            in_func         = '0;
  logic signed [VALUE_BITS-1:0] in_bessel_here  = '0;
  logic signed [VALUE_BITS-1:0] in_bessel_below = '0;
  logic signed [VALUE_BITS-1:0] in_bessel_above = '0;
  logic signed [ORDER_W-1:0]    in_order        = '0;
  logic [ANGLE_BITS-1:0]        in_angle        = '0;
  logic                         out_valid;
  logic                         out_stall       = 1'b0;
  logic signed [OUT_W-1:0]      out_real_part;
  logic signed [OUT_W-1:0]      out_imag_part;

  bessel_phase_rotator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_bessel_here  (in_bessel_here),
    .in_bessel_below (in_bessel_below),
    .in_bessel_above (in_bessel_above),
    .in_order        (in_order),
    .in_angle        (in_angle),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_real_part   (out_real_part),
    .out_imag_part   (out_imag_part)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rotation_scoreboard sb;
  int tx_idle_pct  = IDLE_PCT;
  int rx_stall_pct = IDLE_PCT;
  logic hold_req   = 1'b0;      // raised by stimulus, cleared by the receiver
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Monitor + watchdog. Ports are sampled at the edge, before any NBA lands,
  // so the handshake seen here is exactly what the DUT saw.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rotor_req_t seen;
    bit         moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      seen.func  = in_func;
      seen.here  = in_bessel_here;
      seen.below = in_bessel_below;
      seen.above = in_bessel_above;
      seen.order = in_order;
      seen.angle = in_angle;
      sb.note_input(seen);
      moved = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_real_part, out_imag_part);
      moved = 1'b1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bessel_phase_rotator regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or one long hold when asked (counted here)
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks
  // ---------------------------------------------------------------------------
  // Offer one transaction, idling first at random; returns at the accepting edge.
  // Valid is only lowered in a step that is followed by a wait, never re-raised
  // in the same step.
  task automatic send_item(input int f, input int h, input int b, input int a,
                           input int n, input int p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f[FUNC_W-1:0];
    in_bessel_here  <= h[VALUE_BITS-1:0];
    in_bessel_below <= b[VALUE_BITS-1:0];
    in_bessel_above <= a[VALUE_BITS-1:0];
    in_order        <= n[ORDER_W-1:0];
    in_angle        <= p[ANGLE_BITS-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic int pick_bessel();
    case ($urandom_range(9))
      0:       return J_MAX;
      1:       return J_MIN;
      2:       return $urandom_range(64) - 32;
      default: return $urandom;   // truncated to the field width
    endcase
  endfunction

  // Mostly in-range orders, some raw 8-bit patterns; angles clustered now and
  // then on quadrant edges where the fold kicks in.
  task automatic send_random();
    int f, n, p;
    f = ($urandom_range(9) == 0) ? FN_UNUSED_CODE : $urandom_range(2);
    n = ($urandom_range(4) == 0) ? $urandom : int'($urandom_range(128)) - 64;
    if ($urandom_range(7) == 0)
      p = ($urandom_range(3) << (ANGLE_BITS - 2)) + int'($urandom_range(2)) - 1;
    else
      p = $urandom;
    send_item(f, pick_bessel(), pick_bessel(), pick_bessel(), n, p);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, all selectors, quadrant edges, phase wrap
    send_item(FN_ZERO,   J_MAX, 0, 0, 0, 16'h0000);
    send_item(FN_ZERO,   J_MIN, 0, 0, 1, 16'h4000);
    send_item(FN_ZERO,   J_MAX, 0, 0, -1, 16'h8000);
    send_item(FN_ZERO,   J_MIN, 0, 0, 127, 16'hFFFF);
    send_item(FN_ZERO,   65536, 0, 0, -128, 16'h4000);
    send_item(FN_FIRST,  0, J_MAX, J_MAX, 0, 16'h0000);
    send_item(FN_FIRST,  0, J_MIN, J_MIN, 1, 16'h2000);
    send_item(FN_FIRST,  0, J_MAX, J_MIN, -64, 16'h3FFF);
    send_item(FN_FIRST,  0, J_MIN, J_MAX, 64, 16'hC000);
    send_item(FN_SECOND, 0, J_MAX, J_MAX, 2, 16'h4000);
    send_item(FN_SECOND, 0, J_MAX, J_MIN, -2, 16'h7FFF);
    send_item(FN_SECOND, 0, J_MIN, J_MAX, 64, 16'h0400);   // n*p lands on a full turn
    send_item(FN_SECOND, 0, J_MIN, J_MIN, -64, 16'hBFFF);
    send_item(FN_UNUSED_CODE, J_MIN, J_MIN, J_MIN, -128, 16'hFFFF);
    send_item(FN_UNUSED_CODE, J_MAX, J_MAX, J_MAX, 127, 16'h1234);
    send_item(FN_FIRST,  J_MAX, 0, 0, 5, 16'h9999);
    send_item(FN_ZERO,   1, 0, 0, 3, 16'h5555);
    send_item(FN_FIRST,  0, 1, -1, -128, 16'h8000);
    send_item(FN_SECOND, -7, 12345, -54321, 100, 16'hC001);  // order inside its 8-bit signed range
    send_item(FN_ZERO,   -1, J_MAX, J_MIN, -100, 16'h0001);

    // random with idling on both sides
    repeat (500) send_random();

    // long stretch with no idling at all
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (350) send_random();

    // back-pressure: receiver holds off while the sender keeps offering,
    // so the pipe fills and in_stall rises
    rx_stall_pct = IDLE_PCT;
    hold_req    <= 1'b1;
    repeat (200) send_random();

    // random again
    tx_idle_pct = IDLE_PCT;
    repeat (700) send_random();

    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("bessel_phase_rotator regression: pass");
    end else begin
      $display("bessel_phase_rotator regression: fail");
    end
    $finish;
  end

endmodule
